FILE: design/hsvrgba_pkg.sv
// hsvrgba_pkg: shared constants and types for the HSV to packed RGBA converter.
// No dependencies.
`timescale 1ns / 1ps

package hsvrgba_pkg;

  // Default fraction width: ONE = 2**FRAC_BITS.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Largest channel byte.
  localparam logic [8:0] BYTE_MAX = 9'd255;

  // Hue sectors, sixths of a turn.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW     = 3'd0,
    SEC_YELLOW_GREEN   = 3'd1,
    SEC_GREEN_CYAN     = 3'd2,
    SEC_CYAN_BLUE      = 3'd3,
    SEC_BLUE_MAGENTA   = 3'd4,
    SEC_MAGENTA_RED    = 3'd5
  } sector_t;

endpackage

FILE: design/hsv_to_rgba_packer.sv
// hsv_to_rgba_packer: four-stage pipelined HSV plus alpha to packed 8-bit RGBA.
// Depends on hsvrgba_pkg.
`timescale 1ns / 1ps

//  channel   ports                                   handshake
//  -------   -------------------------------------   ------------------------
//  input     in_hue, in_saturation, in_brightness,   transfer when start && !busy
//            in_opacity
//  result    out_packed_rgba                         one-cycle strobe out_valid
//
// One item enters per clock; each result moves through the stage registers in order
// and is taken at the following edge once on the outputs (stage 1: hue*6, clamps;
// stage 2: p, s*f, s*(1-f); stage 3: q, t; stage 4: sector select and byte
// scaling into the output register). The depth comes from the two dependent
// multiply levels. rst_n (synchronous) clears only the stage valid bits; data
// regs are not reset. The receiver cannot stall, so busy is always low.

module hsv_to_rgba_packer #(
  parameter int unsigned FRAC_BITS = hsvrgba_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  logic [FRAC_BITS-1:0] in_hue,
  input  logic [FRAC_BITS:0]   in_saturation,
  input  logic [FRAC_BITS:0]   in_brightness,
  input  logic [FRAC_BITS:0]   in_opacity,
  // result channel
  output logic                 out_valid,
  output logic [31:0]          out_packed_rgba
);

  localparam int unsigned F = FRAC_BITS;
  // 1.0 in the fraction format
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // Clamp a fraction to 1.0.
  function automatic logic [F:0] sat_one(input logic [F:0] x);
    sat_one = (x > ONE) ? ONE : x;
  endfunction

  // floor(x*255 / ONE), limited to 255. x*255 is formed as x*256 - x.
  function automatic logic [7:0] to_byte(input logic [F:0] x);
    logic [F+8:0] m;
    logic [8:0]   hi;
    m  = {x, 8'b0} - {8'b0, x};
    hi = m[F+8:F];
    to_byte = (hi > hsvrgba_pkg::BYTE_MAX) ? 8'hFF : hi[7:0];
  endfunction

  // The receiver never stalls the pipeline.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: clamp fractions, hue*6 -> sector and fraction
  // ---------------------------------------------------------------------------
  logic                 v1_r;
  hsvrgba_pkg::sector_t sec1_r, sec1_nxt;
  logic [F-1:0]         f1_r, f1_nxt;
  logic [F:0]           s1_r, s1_nxt;
  logic [F:0]           br1_r, br1_nxt;
  logic [F:0]           a1_r, a1_nxt;
  logic [F+2:0]         h6;

  always_comb begin
    h6       = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};
    sec1_nxt = hsvrgba_pkg::sector_t'(h6[F+2:F]);
    f1_nxt   = h6[F-1:0];
    s1_nxt   = sat_one(in_saturation);
    br1_nxt  = sat_one(in_brightness);
    a1_nxt   = sat_one(in_opacity);
  end

  // ---------------------------------------------------------------------------
  // Stage 2: p = v(1-s), sf = s*f, sg = s*(1-f)
  // ---------------------------------------------------------------------------
  logic                 v2_r;
  hsvrgba_pkg::sector_t sec2_r;
  logic [F:0]           br2_r, a2_r;
  logic [F:0]           p2_r, p2_nxt;
  logic [F:0]           sf2_r, sf2_nxt;
  logic [F:0]           sg2_r, sg2_nxt;
  // products of two fractions at or below ONE fit in 2F+1 bits
  logic [2*F:0]         prod_p;
  logic [2*F:0]         prod_sf;
  logic [2*F:0]         prod_sg;

  always_comb begin
    prod_p  = (2*F+1)'(br1_r) * (2*F+1)'(ONE - s1_r);
    prod_sf = (2*F+1)'(s1_r) * (2*F+1)'(f1_r);
    prod_sg = (2*F+1)'(s1_r) * (2*F+1)'(ONE - {1'b0, f1_r});
    // all three stay at or below ONE
    p2_nxt  = prod_p[2*F:F];
    sf2_nxt = prod_sf[2*F:F];
    sg2_nxt = prod_sg[2*F:F];
  end

  // ---------------------------------------------------------------------------
  // Stage 3: q = v(1-sf), t = v(1-sg)
  // ---------------------------------------------------------------------------
  logic                 v3_r;
  hsvrgba_pkg::sector_t sec3_r;
  logic [F:0]           br3_r, a3_r, p3_r;
  logic [F:0]           q3_r, q3_nxt;
  logic [F:0]           t3_r, t3_nxt;
  logic [2*F:0]         prod_q;
  logic [2*F:0]         prod_t;

  always_comb begin
    prod_q = (2*F+1)'(br2_r) * (2*F+1)'(ONE - sf2_r);
    prod_t = (2*F+1)'(br2_r) * (2*F+1)'(ONE - sg2_r);
    q3_nxt = prod_q[2*F:F];
    t3_nxt = prod_t[2*F:F];
  end

  // ---------------------------------------------------------------------------
  // Stage 4: permutation by sector, scale to bytes, pack.
  // Zero saturation needs no special path: p = q = t = v then, so every
  // sector gives grey.
  // ---------------------------------------------------------------------------
  logic        out_valid_r;
  logic [31:0] out_packed_rgba_r, out_packed_rgba_nxt;
  logic [F:0]  ch_r, ch_g, ch_b;

  always_comb begin
    case (sec3_r)
      hsvrgba_pkg::SEC_RED_YELLOW: begin
        ch_r = br3_r; ch_g = t3_r;  ch_b = p3_r;
      end
      hsvrgba_pkg::SEC_YELLOW_GREEN: begin
        ch_r = q3_r;  ch_g = br3_r; ch_b = p3_r;
      end
      hsvrgba_pkg::SEC_GREEN_CYAN: begin
        ch_r = p3_r;  ch_g = br3_r; ch_b = t3_r;
      end
      hsvrgba_pkg::SEC_CYAN_BLUE: begin
        ch_r = p3_r;  ch_g = q3_r;  ch_b = br3_r;
      end
      hsvrgba_pkg::SEC_BLUE_MAGENTA: begin
        ch_r = t3_r;  ch_g = p3_r;  ch_b = br3_r;
      end
      default: begin
        ch_r = br3_r; ch_g = p3_r;  ch_b = q3_r;
      end
    endcase
    out_packed_rgba_nxt = {to_byte(ch_r), to_byte(ch_g), to_byte(ch_b), to_byte(a3_r)};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // data path, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      sec1_r <= sec1_nxt;
      f1_r   <= f1_nxt;
      s1_r   <= s1_nxt;
      br1_r  <= br1_nxt;
      a1_r   <= a1_nxt;
    end
    if (v1_r) begin
      sec2_r <= sec1_r;
      br2_r  <= br1_r;
      a2_r   <= a1_r;
      p2_r   <= p2_nxt;
      sf2_r  <= sf2_nxt;
      sg2_r  <= sg2_nxt;
    end
    if (v2_r) begin
      sec3_r <= sec2_r;
      br3_r  <= br2_r;
      a3_r   <= a2_r;
      p3_r   <= p2_r;
      q3_r   <= q3_nxt;
      t3_r   <= t3_nxt;
    end
    if (v3_r) begin
      out_packed_rgba_r <= out_packed_rgba_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packed_rgba = out_packed_rgba_r;

`ifndef SYNTHESIS
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (sec1_r == hsvrgba_pkg::SEC_RED_YELLOW   ||
              sec1_r == hsvrgba_pkg::SEC_YELLOW_GREEN ||
              sec1_r == hsvrgba_pkg::SEC_GREEN_CYAN   ||
              sec1_r == hsvrgba_pkg::SEC_CYAN_BLUE    ||
              sec1_r == hsvrgba_pkg::SEC_BLUE_MAGENTA ||
              sec1_r == hsvrgba_pkg::SEC_MAGENTA_RED))
    else $error("hue sector out of range");

  a_pqt_below_v: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (p3_r <= br3_r && q3_r <= br3_r && t3_r <= br3_r))
    else $error("p/q/t exceed brightness");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |=> out_valid)
    else $error("result strobe lost");
`endif

endmodule
